@@ hw/rtl/rdsat_pkg.sv @@
// rdsat_pkg: shared types and constants of the reliable delivery tracker
// holds field widths, action and result codes and the sequencer state type
// no dependencies
package rdsat_pkg;

	// fixed field widths
	localparam int ACTION_W    = 3;
	localparam int SEQ_IN_W    = 32;
	localparam int KIND_W      = 4;
	localparam int TIME_W      = 32;
	localparam int TIMEOUT_W   = 16;

	// timeout register value after reset
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5;

	// cap on results produced by one tick or one drain
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	// action codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_SEND  = 3'd0,
		ACT_RECV  = 3'd1,
		ACT_ACK   = 3'd2,
		ACT_TICK  = 3'd3,
		ACT_DRAIN = 3'd4,
		ACT_CLEAR = 3'd5
	} action_t;

	// result codes
	typedef enum logic [KIND_W-1:0] {
		RK_ASSIGNED   = 4'd0,
		RK_ACCEPTED   = 4'd1,
		RK_STALE      = 4'd2,
		RK_DELIVERED  = 4'd3,
		RK_UNKNOWN    = 4'd4,
		RK_TIMED_OUT  = 4'd5,
		RK_ACK_OUT    = 4'd6,
		RK_TABLE_FULL = 4'd7,
		RK_QUEUE_FULL = 4'd8
	} kind_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RECV,
		ST_SEND,
		ST_ACK_RD,
		ST_ACK_CMP,
		ST_TICK_RD,
		ST_TICK_AGE,
		ST_TICK_CMP,
		ST_DRAIN_RD,
		ST_DRAIN_OUT,
		ST_FLUSH
	} state_t;

endpackage

@@ hw/rtl/rdsat_if.sv @@
// rdsat channel interfaces: command, result and configuration write channels
// each carries valid, ready and its payload, with source and sink modports
// depends on rdsat_pkg for field widths

// command channel
interface rdsat_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [rdsat_pkg::ACTION_W-1:0]     action;
	logic [rdsat_pkg::SEQ_IN_W-1:0]     seq_number;

	modport source (output valid, output action, output seq_number, input ready);
	modport sink   (input valid, input action, input seq_number, output ready);
endinterface

// result channel
interface rdsat_res_if;
	logic                               valid;
	logic                               ready;
	logic [rdsat_pkg::KIND_W-1:0]       result_kind;
	logic [rdsat_pkg::SEQ_IN_W-1:0]     result_seq;
	logic                               last_of_run;

	modport source (output valid, output result_kind, output result_seq,
		output last_of_run, input ready);
	modport sink   (input valid, input result_kind, input result_seq,
		input last_of_run, output ready);
endinterface

// configuration write channel, timeout register only
interface rdsat_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [rdsat_pkg::TIMEOUT_W-1:0]    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/reliable_delivery_seq_ack_tracker.sv @@
// reliable_delivery_seq_ack_tracker: sequencer over one shared subtract/compare unit
// receive compares with the expected number; send scans for a free slot;
//   ack reads and compares each entry; tick also ages each entry; drain emits queued acks
// one transaction at a time: the next command is taken once the last result
//   has moved into the output register
// reset clears control, counters and pending valid bits; the memories need no clearing
module reliable_delivery_seq_ack_tracker #(
	parameter int PENDING_DEPTH = 16,
	parameter int ACK_DEPTH     = 16,
	parameter int SEQ_WIDTH     = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	rdsat_cfg_if.sink    cfg,
	rdsat_cmd_if.sink    cmd,
	rdsat_res_if.source  res
);

	localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int AIW = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
	localparam int ACW = $clog2(ACK_DEPTH + 1);
	localparam int UW  = (SEQ_WIDTH > rdsat_pkg::TIME_W) ? SEQ_WIDTH : rdsat_pkg::TIME_W;
	localparam int RW  = rdsat_pkg::RES_CNT_W;
	localparam int TW  = rdsat_pkg::TIME_W;

	// sequencer state
	rdsat_pkg::state_t state_q, state_d;

	// architectural state
	logic [rdsat_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [SEQ_WIDTH-1:0]            next_send_q;
	logic [SEQ_WIDTH-1:0]            next_exp_q;
	logic [TW-1:0]                   time_q;
	logic [PENDING_DEPTH-1:0]        valid_q;
	logic [AIW-1:0]                  head_q;
	logic [AIW-1:0]                  tail_q;
	logic [ACW-1:0]                  ack_count_q;

	// per-transaction registers
	logic [SEQ_WIDTH-1:0]            seq_q;
	logic [PIW-1:0]                  idx_q;
	logic [RW-1:0]                   nres_q;
	logic [RW-1:0]                   drain_left_q;
	logic [TW-1:0]                   age_q;

	// memories and their read registers
	logic [SEQ_WIDTH-1:0]            pend_seq_mem [PENDING_DEPTH];
	logic [TW-1:0]                   pend_time_mem [PENDING_DEPTH];
	logic [SEQ_WIDTH-1:0]            ack_mem [ACK_DEPTH];
	logic [SEQ_WIDTH-1:0]            rd_seq_q;
	logic [TW-1:0]                   rd_time_q;
	logic [SEQ_WIDTH-1:0]            q_rdata_q;

	// held result and output register
	logic                            hold_valid_q;
	rdsat_pkg::kind_t                hold_kind_q;
	logic [SEQ_WIDTH-1:0]            hold_seq_q;
	logic                            out_valid_q;
	rdsat_pkg::kind_t                out_kind_q;
	logic [SEQ_WIDTH-1:0]            out_seq_q;
	logic                            out_last_q;

	// shared unit
	logic [UW-1:0]                   u_a, u_b;
	logic [UW:0]                     u_diff;
	logic                            u_borrow, u_zero;

	// control
	logic                            cmd_ready;
	logic                            cmd_fire;
	logic                            emit_req, emit_ok, emit_fire, stall;
	rdsat_pkg::kind_t                emit_kind;
	logic [SEQ_WIDTH-1:0]            emit_seq;
	logic                            flush_req, out_free, push;
	logic                            pend_wr, pend_rd, valid_clr, idx_inc;
	logic                            q_wr, q_rd, q_pop, age_ld;
	logic                            idx_last, q_full, tick_hit, res_last;

	// status
	assign out_free  = !out_valid_q || res.ready;
	assign emit_ok   = !hold_valid_q || out_free;
	assign stall     = emit_req && !emit_ok;
	assign emit_fire = emit_req && emit_ok;
	assign idx_last  = (idx_q == PIW'(PENDING_DEPTH - 1));
	assign q_full    = (ack_count_q == ACW'(ACK_DEPTH));
	assign cmd_fire  = cmd.valid && cmd_ready;
	assign tick_hit  = valid_q[idx_q] && u_borrow;
	assign res_last  = (nres_q == RW'(rdsat_pkg::MAX_RESULTS - 1));

	// shared subtract/compare unit operand select
	always_comb begin
		u_a = '0;
		u_b = '0;
		case (state_q)
			rdsat_pkg::ST_RECV: begin
				u_a = UW'(seq_q);
				u_b = UW'(next_exp_q);
			end
			rdsat_pkg::ST_ACK_CMP: begin
				u_a = UW'(seq_q);
				u_b = UW'(rd_seq_q);
			end
			rdsat_pkg::ST_TICK_AGE: begin
				u_a = UW'(time_q);
				u_b = UW'(rd_time_q);
			end
			rdsat_pkg::ST_TICK_CMP: begin
				u_a = UW'(timeout_q);
				u_b = UW'(age_q);
			end
			default: begin
				u_a = '0;
				u_b = '0;
			end
		endcase
	end

	assign u_diff   = {1'b0, u_a} - {1'b0, u_b};
	assign u_borrow = u_diff[UW];
	assign u_zero   = (u_diff[UW-1:0] == '0);

	// sequencer outputs
	always_comb begin
		cmd_ready = 1'b0;
		emit_req  = 1'b0;
		emit_kind = rdsat_pkg::RK_ASSIGNED;
		emit_seq  = '0;
		flush_req = 1'b0;
		pend_wr   = 1'b0;
		pend_rd   = 1'b0;
		valid_clr = 1'b0;
		idx_inc   = 1'b0;
		q_wr      = 1'b0;
		q_rd      = 1'b0;
		q_pop     = 1'b0;
		age_ld    = 1'b0;
		case (state_q)
			rdsat_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
			end
			rdsat_pkg::ST_RECV: begin
				emit_req = 1'b1;
				emit_seq = seq_q;
				if (u_borrow) begin
					emit_kind = rdsat_pkg::RK_STALE;
				end else if (q_full) begin
					emit_kind = rdsat_pkg::RK_QUEUE_FULL;
				end else begin
					emit_kind = rdsat_pkg::RK_ACCEPTED;
					q_wr      = emit_ok;
				end
			end
			rdsat_pkg::ST_SEND: begin
				if (!valid_q[idx_q]) begin
					emit_req  = 1'b1;
					emit_kind = rdsat_pkg::RK_ASSIGNED;
					emit_seq  = next_send_q;
					pend_wr   = emit_ok;
				end else if (idx_last) begin
					emit_req  = 1'b1;
					emit_kind = rdsat_pkg::RK_TABLE_FULL;
					emit_seq  = next_send_q;
				end else begin
					idx_inc = 1'b1;
				end
			end
			rdsat_pkg::ST_ACK_RD: begin
				pend_rd = 1'b1;
			end
			rdsat_pkg::ST_ACK_CMP: begin
				emit_seq = seq_q;
				if (valid_q[idx_q] && u_zero) begin
					emit_req  = 1'b1;
					emit_kind = rdsat_pkg::RK_DELIVERED;
					valid_clr = emit_ok;
				end else if (idx_last) begin
					emit_req  = 1'b1;
					emit_kind = rdsat_pkg::RK_UNKNOWN;
				end else begin
					idx_inc = 1'b1;
				end
			end
			rdsat_pkg::ST_TICK_RD: begin
				pend_rd = 1'b1;
			end
			rdsat_pkg::ST_TICK_AGE: begin
				age_ld = 1'b1;
			end
			rdsat_pkg::ST_TICK_CMP: begin
				emit_kind = rdsat_pkg::RK_TIMED_OUT;
				emit_seq  = rd_seq_q;
				if (tick_hit) begin
					emit_req  = 1'b1;
					valid_clr = emit_ok;
				end
				idx_inc = !(tick_hit && !emit_ok) && !idx_last && !(tick_hit && res_last);
			end
			rdsat_pkg::ST_DRAIN_RD: begin
				q_rd = (drain_left_q != '0);
			end
			rdsat_pkg::ST_DRAIN_OUT: begin
				emit_req  = 1'b1;
				emit_kind = rdsat_pkg::RK_ACK_OUT;
				emit_seq  = q_rdata_q;
				q_pop     = emit_ok;
			end
			rdsat_pkg::ST_FLUSH: begin
				flush_req = 1'b1;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rdsat_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					case (rdsat_pkg::action_t'(cmd.action))
						rdsat_pkg::ACT_SEND:  state_d = rdsat_pkg::ST_SEND;
						rdsat_pkg::ACT_RECV:  state_d = rdsat_pkg::ST_RECV;
						rdsat_pkg::ACT_ACK:   state_d = rdsat_pkg::ST_ACK_RD;
						rdsat_pkg::ACT_TICK:  state_d = rdsat_pkg::ST_TICK_RD;
						rdsat_pkg::ACT_DRAIN: state_d = rdsat_pkg::ST_DRAIN_RD;
						default:              state_d = rdsat_pkg::ST_IDLE;
					endcase
				end
			end
			rdsat_pkg::ST_RECV: begin
				if (!stall) state_d = rdsat_pkg::ST_FLUSH;
			end
			rdsat_pkg::ST_SEND: begin
				if (emit_fire) state_d = rdsat_pkg::ST_FLUSH;
			end
			rdsat_pkg::ST_ACK_RD: begin
				state_d = rdsat_pkg::ST_ACK_CMP;
			end
			rdsat_pkg::ST_ACK_CMP: begin
				if (emit_fire) begin
					state_d = rdsat_pkg::ST_FLUSH;
				end else if (!emit_req) begin
					state_d = rdsat_pkg::ST_ACK_RD;
				end
			end
			rdsat_pkg::ST_TICK_RD: begin
				state_d = rdsat_pkg::ST_TICK_AGE;
			end
			rdsat_pkg::ST_TICK_AGE: begin
				state_d = rdsat_pkg::ST_TICK_CMP;
			end
			rdsat_pkg::ST_TICK_CMP: begin
				if (!stall) begin
					if (idx_last || (tick_hit && res_last)) begin
						state_d = rdsat_pkg::ST_FLUSH;
					end else begin
						state_d = rdsat_pkg::ST_TICK_RD;
					end
				end
			end
			rdsat_pkg::ST_DRAIN_RD: begin
				if (drain_left_q == '0) begin
					state_d = rdsat_pkg::ST_FLUSH;
				end else begin
					state_d = rdsat_pkg::ST_DRAIN_OUT;
				end
			end
			rdsat_pkg::ST_DRAIN_OUT: begin
				if (!stall) state_d = rdsat_pkg::ST_DRAIN_RD;
			end
			rdsat_pkg::ST_FLUSH: begin
				if (!hold_valid_q || out_free) state_d = rdsat_pkg::ST_IDLE;
			end
			default: begin
				state_d = rdsat_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdsat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rdsat_pkg::TIMEOUT_RESET;
		end else if (cfg.valid) begin
			timeout_q <= cfg.data;
		end
	end

	assign cfg.ready = 1'b1;

	// sender, receiver and time state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_send_q <= '0;
			next_exp_q  <= '0;
			time_q      <= '0;
			valid_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			ack_count_q <= '0;
		end else begin
			if (cmd_fire && (cmd.action == rdsat_pkg::ACT_CLEAR)) begin
				next_send_q <= '0;
				next_exp_q  <= '0;
				time_q      <= '0;
				valid_q     <= '0;
				head_q      <= '0;
				tail_q      <= '0;
				ack_count_q <= '0;
			end else begin
				if (cmd_fire && (cmd.action == rdsat_pkg::ACT_TICK)) begin
					time_q <= time_q + TW'(1);
				end
				if (pend_wr) begin
					valid_q[idx_q] <= 1'b1;
					next_send_q    <= next_send_q + SEQ_WIDTH'(1);
				end
				if (valid_clr) begin
					valid_q[idx_q] <= 1'b0;
				end
				if (q_wr) begin
					next_exp_q  <= seq_q + SEQ_WIDTH'(1);
					tail_q      <= (tail_q == AIW'(ACK_DEPTH - 1)) ? '0 : tail_q + AIW'(1);
					ack_count_q <= ack_count_q + ACW'(1);
				end
				if (q_pop) begin
					head_q      <= (head_q == AIW'(ACK_DEPTH - 1)) ? '0 : head_q + AIW'(1);
					ack_count_q <= ack_count_q - ACW'(1);
				end
			end
		end
	end

	// per-transaction counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			nres_q       <= '0;
			drain_left_q <= '0;
		end else begin
			if (cmd_fire) begin
				idx_q  <= '0;
				nres_q <= '0;
				if (32'(ack_count_q) > rdsat_pkg::MAX_RESULTS) begin
					drain_left_q <= RW'(rdsat_pkg::MAX_RESULTS);
				end else begin
					drain_left_q <= RW'(ack_count_q);
				end
			end else begin
				if (idx_inc) idx_q <= idx_q + PIW'(1);
				if (emit_fire && (state_q == rdsat_pkg::ST_TICK_CMP)) nres_q <= nres_q + RW'(1);
				if (q_pop) drain_left_q <= drain_left_q - RW'(1);
			end
		end
	end

	// command payload and age registers
	always_ff @(posedge clk) begin
		if (cmd_fire) seq_q <= SEQ_WIDTH'(cmd.seq_number);
		if (age_ld) age_q <= u_diff[TW-1:0];
	end

	// pending table memories
	always_ff @(posedge clk) begin
		if (pend_wr) begin
			pend_seq_mem[idx_q]  <= next_send_q;
			pend_time_mem[idx_q] <= time_q;
		end
		if (pend_rd) begin
			rd_seq_q  <= pend_seq_mem[idx_q];
			rd_time_q <= pend_time_mem[idx_q];
		end
	end

	// ack queue memory
	always_ff @(posedge clk) begin
		if (q_wr) ack_mem[tail_q] <= seq_q;
		if (q_rd) q_rdata_q <= ack_mem[head_q];
	end

	// held result: the newest result waits until the next one or the end of the run
	assign push = hold_valid_q && ((emit_fire) || (flush_req && out_free));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (emit_fire) begin
			hold_valid_q <= 1'b1;
		end else if (flush_req && out_free) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			hold_kind_q <= emit_kind;
			hold_seq_q  <= emit_seq;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q <= hold_kind_q;
			out_seq_q  <= hold_seq_q;
			out_last_q <= flush_req;
		end
	end

	assign cmd.ready       = cmd_ready;
	assign res.valid       = out_valid_q;
	assign res.result_kind = out_kind_q;
	assign res.result_seq  = rdsat_pkg::SEQ_IN_W'(out_seq_q);
	assign res.last_of_run = out_last_q;

endmodule
